// File: design/jlrv_pkg.sv
// ----------------------------------------------------------------------------
// jlrv_pkg
// Shared types and constants for the joint-limit repulsion velocity block.
// ----------------------------------------------------------------------------
package jlrv_pkg;

    localparam int IDX_W   = 5;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int DIST_W  = 32;
    localparam int RECIP_W = 33;
    localparam int DIFF_W  = RECIP_W + 1;
    localparam int LO_W    = 17;
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int PROD_W  = DATA_W + DIFF_W;
    localparam int VEL_W   = PROD_W - 16;

    localparam logic CFG_GAIN  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic                     zero;
        logic signed [DATA_W-1:0] vmax;
        logic [DIST_W-1:0]        d_lo;
        logic [DIST_W-1:0]        d_hi;
    } mid_item_t;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         idx;
        logic                     zero;
        logic signed [DATA_W-1:0] vmax;
    } side_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] vel;
    } out_item_t;

endpackage

// File: design/jlrv_fifo.sv
// ----------------------------------------------------------------------------
// jlrv_fifo
// Small synchronous queue used between the front and back and at the output.
// ----------------------------------------------------------------------------
module jlrv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule

// File: design/jlrv_front.sv
// ----------------------------------------------------------------------------
// jlrv_front
// Classify a joint beat and form both floored limit distances.
// ----------------------------------------------------------------------------
module jlrv_front #(
    parameter int MAX_JOINTS = 32
) (
    input  logic [jlrv_pkg::IDX_W-1:0]         joint_index,
    input  logic                               limit_set,
    input  logic signed [jlrv_pkg::DATA_W-1:0] position,
    input  logic signed [jlrv_pkg::DATA_W-1:0] lower_limit,
    input  logic signed [jlrv_pkg::DATA_W-1:0] upper_limit,
    input  logic signed [jlrv_pkg::DATA_W-1:0] vel_limit,
    input  logic signed [jlrv_pkg::DATA_W-1:0] gain,
    input  logic [5:0]                         joint_count,
    output jlrv_pkg::mid_item_t                item
);
    logic [jlrv_pkg::CNT_W-1:0]        active;
    logic signed [jlrv_pkg::DATA_W:0]  dl, dh;

    always_comb
    begin
        if (jlrv_pkg::CNT_W'(joint_count) > jlrv_pkg::CNT_W'(MAX_JOINTS))
        begin
            active = jlrv_pkg::CNT_W'(MAX_JOINTS);
        end
        else
        begin
            active = jlrv_pkg::CNT_W'(joint_count);
        end
        dl = $signed({position[31], position}) - $signed({lower_limit[31], lower_limit});
        dh = $signed({upper_limit[31], upper_limit}) - $signed({position[31], position});
        item.idx  = joint_index;
        item.vmax = vel_limit;
        item.zero = (jlrv_pkg::CNT_W'(joint_index) >= active) || !limit_set
                    || (upper_limit <= lower_limit) || (gain == '0);
        // floor each distance at one LSB
        item.d_lo = (dl <= 0) ? jlrv_pkg::DIST_W'(1) : dl[jlrv_pkg::DIST_W-1:0];
        item.d_hi = (dh <= 0) ? jlrv_pkg::DIST_W'(1) : dh[jlrv_pkg::DIST_W-1:0];
    end

endmodule

// File: design/jlrv_recip.sv
// ----------------------------------------------------------------------------
// jlrv_recip
// Pipelined restoring divider: floor(2^32 / d), one quotient bit per stage.
// ----------------------------------------------------------------------------
module jlrv_recip (
    input  logic                                clk,
    input  logic                                adv,
    input  logic [jlrv_pkg::DIST_W-1:0]         d,
    output logic [jlrv_pkg::RECIP_W-1:0]        recip
);
    localparam int NS = jlrv_pkg::RECIP_W;

    logic [jlrv_pkg::DIST_W-1:0]  d_reg   [NS];
    logic [jlrv_pkg::DIST_W-1:0]  rem_reg [NS];
    logic [jlrv_pkg::RECIP_W-1:0] q_reg   [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [jlrv_pkg::DIST_W-1:0]  d_in, rem_in, rem_next;
        logic [jlrv_pkg::RECIP_W-1:0] q_in, q_next;
        logic [jlrv_pkg::DIST_W:0]    trial;
        logic                         qbit;

        if (k == 0)
        begin : g_first
            assign d_in   = d;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign d_in   = d_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            // dividend is 2^32: only its top bit is set
            trial    = {rem_in, (k == 0) ? 1'b1 : 1'b0};
            qbit     = (trial >= {1'b0, d_in});
            rem_next = qbit ? jlrv_pkg::DIST_W'(trial - {1'b0, d_in})
                            : trial[jlrv_pkg::DIST_W-1:0];
            q_next   = {q_in[jlrv_pkg::RECIP_W-2:0], qbit};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[k]   <= d_in;
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign recip = q_reg[NS-1];

endmodule

// File: design/jlrv_back.sv
// ----------------------------------------------------------------------------
// jlrv_back
// Reciprocals, difference, gain multiply, floor shift, clamp, saturation and zeroing.
// ----------------------------------------------------------------------------
module jlrv_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [jlrv_pkg::DATA_W-1:0] gain,
    input  jlrv_pkg::mid_item_t                item,
    input  logic                               item_valid,
    output logic                               item_pop,
    input  logic                               out_full,
    output logic                               out_push,
    output jlrv_pkg::out_item_t                out_item
);
    localparam int NS = jlrv_pkg::RECIP_W;

    logic                                     adv;
    logic [jlrv_pkg::RECIP_W-1:0]             r_lo, r_hi;
    jlrv_pkg::side_t                          sb_reg [NS];
    jlrv_pkg::side_t                          sa_reg, sbb_reg, sc_reg;
    logic signed [jlrv_pkg::DIFF_W-1:0]       diff_reg;
    logic signed [jlrv_pkg::DATA_W+jlrv_pkg::HI_W-1:0]   pph_reg;
    logic signed [jlrv_pkg::DATA_W+jlrv_pkg::LO_W:0]     ppl_reg;
    logic signed [jlrv_pkg::VEL_W-1:0]        v_reg;
    logic signed [jlrv_pkg::PROD_W-1:0]       prod;
    logic signed [jlrv_pkg::VEL_W-1:0]        vmax_x, vc;
    jlrv_pkg::side_t                          sin;

    // whole pipeline holds while the output queue is full
    assign adv      = !out_full;
    assign item_pop = adv && item_valid;

    always_comb
    begin
        sin.valid = item_valid;
        sin.idx   = item.idx;
        sin.zero  = item.zero;
        sin.vmax  = item.vmax;
    end

    jlrv_recip u_recip_lo (.clk(clk), .adv(adv), .d(item.d_lo), .recip(r_lo));
    jlrv_recip u_recip_hi (.clk(clk), .adv(adv), .d(item.d_hi), .recip(r_hi));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                sb_reg[k].valid <= 1'b0;
            end
            sa_reg.valid  <= 1'b0;
            sbb_reg.valid <= 1'b0;
            sc_reg.valid  <= 1'b0;
        end
        else if (adv)
        begin
            sb_reg[0] <= sin;
            for (int k = 1; k < NS; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
            sa_reg  <= sb_reg[NS-1];
            sbb_reg <= sa_reg;
            sc_reg  <= sbb_reg;
        end
    end

    assign prod = (jlrv_pkg::PROD_W'(pph_reg) <<< jlrv_pkg::LO_W)
                  + jlrv_pkg::PROD_W'(ppl_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= $signed({1'b0, r_lo}) - $signed({1'b0, r_hi});
            pph_reg  <= gain * $signed(diff_reg[jlrv_pkg::DIFF_W-1:jlrv_pkg::LO_W]);
            ppl_reg  <= gain * $signed({1'b0, diff_reg[jlrv_pkg::LO_W-1:0]});
            // arithmetic shift floors toward minus infinity
            v_reg    <= jlrv_pkg::VEL_W'(prod >>> 16);
        end
    end

    always_comb
    begin
        vmax_x = jlrv_pkg::VEL_W'(sc_reg.vmax);
        vc     = v_reg;
        if (sc_reg.vmax > 0)
        begin
            if (vc > vmax_x)
            begin
                vc = vmax_x;
            end
            else if (vc < -vmax_x)
            begin
                vc = -vmax_x;
            end
        end
        if (vc > jlrv_pkg::VEL_W'(32'sh7FFF_FFFF))
        begin
            out_item.vel = 32'sh7FFF_FFFF;
        end
        else if (vc < -jlrv_pkg::VEL_W'(33'sh0_8000_0000))
        begin
            out_item.vel = 32'sh8000_0000;
        end
        else
        begin
            out_item.vel = vc[jlrv_pkg::DATA_W-1:0];
        end
        if (sc_reg.zero)
        begin
            out_item.vel = '0;
        end
        out_item.idx = sc_reg.idx;
    end

    assign out_push = adv && sc_reg.valid;

endmodule

// File: design/joint_limit_repulsion_velocity.sv
// ----------------------------------------------------------------------------
// joint_limit_repulsion_velocity
// Potential-field joint limit repulsion: gain * (1/(q-lo) - 1/(hi-q)), Q16.16.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | push / full             | joint_index, limit_set, position,
//           |                         | lower_limit, upper_limit, vel_limit
//  result   | empty / pop             | joint_out, velocity
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One beat per cycle sustained while the result queue is not full.
//  A beat passes the 33 stages of the two parallel restoring reciprocal
//  dividers, then the difference, the split gain multiply and the floor shift.
//  Reset clears gain and joint count and empties both queues.
//  A full output queue holds the whole back pipeline; the 4-entry middle
//  queue then absorbs input beats until full rises.
// ----------------------------------------------------------------------------
module joint_limit_repulsion_velocity #(
    parameter int MAX_JOINTS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [jlrv_pkg::IDX_W-1:0]         joint_index,
    input  logic                               limit_set,
    input  logic signed [jlrv_pkg::DATA_W-1:0] position,
    input  logic signed [jlrv_pkg::DATA_W-1:0] lower_limit,
    input  logic signed [jlrv_pkg::DATA_W-1:0] upper_limit,
    input  logic signed [jlrv_pkg::DATA_W-1:0] vel_limit,
    output logic                               empty,
    input  logic                               pop,
    output logic [jlrv_pkg::IDX_W-1:0]         joint_out,
    output logic signed [jlrv_pkg::DATA_W-1:0] velocity,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [jlrv_pkg::DATA_W-1:0]        cfg_data
);
    logic signed [jlrv_pkg::DATA_W-1:0] gain_reg;
    logic [5:0]                         joint_count_reg;
    jlrv_pkg::mid_item_t                front_item, mid_item;
    jlrv_pkg::out_item_t                back_item, res_item;
    logic                               mid_empty, mid_pop, out_full, out_push;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= '0;
            joint_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                jlrv_pkg::CFG_GAIN:  gain_reg        <= $signed(cfg_data);
                jlrv_pkg::CFG_COUNT: joint_count_reg <= cfg_data[5:0];
                default:             gain_reg        <= gain_reg;
            endcase
        end
    end

    // classify and form distances
    jlrv_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
        .joint_index (joint_index),
        .limit_set   (limit_set),
        .position    (position),
        .lower_limit (lower_limit),
        .upper_limit (upper_limit),
        .vel_limit   (vel_limit),
        .gain        (gain_reg),
        .joint_count (joint_count_reg),
        .item        (front_item)
    );

    // decouple front from back
    jlrv_fifo #(.WIDTH($bits(jlrv_pkg::mid_item_t)), .DEPTH(4)) u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (front_item),
        .full (full),
        .pop  (mid_pop),
        .dout (mid_item),
        .empty(mid_empty)
    );

    jlrv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .item      (mid_item),
        .item_valid(!mid_empty),
        .item_pop  (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (back_item)
    );

    // result queue: parts the pipeline from the consumer
    jlrv_fifo #(.WIDTH($bits(jlrv_pkg::out_item_t)), .DEPTH(2)) u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (out_push),
        .din  (back_item),
        .full (out_full),
        .pop  (pop),
        .dout (res_item),
        .empty(empty)
    );

    assign joint_out = res_item.idx;
    assign velocity  = res_item.vel;

endmodule

// File: dv/tb_joint_limit_repulsion_velocity.sv
// ----------------------------------------------------------------------------
// tb_joint_limit_repulsion_velocity
// Self-checking bench: random bursty pushes and pops against a predictor of
// the Q16.16 repulsion velocity, over several gain and joint-count settings.
// ----------------------------------------------------------------------------
module tb_joint_limit_repulsion_velocity;

    localparam int LATENCY = 37;

    // one joint beat as presented on the input side
    typedef struct {
        logic [4:0]         idx;
        logic               lim;
        logic signed [31:0] q;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] vmax;
    } joint_beat_t;

    typedef struct {
        logic [4:0]         idx;
        logic signed [31:0] vel;
    } velocity_beat_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [4:0] joint_index;
    logic limit_set;
    logic signed [31:0] position;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic signed [31:0] vel_limit;
    logic empty;
    logic pop;
    logic [4:0] joint_out;
    logic signed [31:0] velocity;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;

    joint_beat_t    pending_joints[$];
    velocity_beat_t expected_velocities[$];

    // predictor copy of the registers
    logic signed [31:0] model_gain;
    logic [5:0]         model_count;

    int mismatches;
    int burst_left;
    int gap_left;
    int pop_phase;
    bit pop_mode;

    joint_limit_repulsion_velocity u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .joint_index(joint_index), .limit_set(limit_set), .position(position),
        .lower_limit(lower_limit), .upper_limit(upper_limit),
        .vel_limit(vel_limit), .empty(empty), .pop(pop),
        .joint_out(joint_out), .velocity(velocity), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor(2^32 / d) with d floored at one LSB
    function automatic logic signed [63:0] recip_of_distance(logic signed [63:0] d);
        if (d < 1)
            d = 1;
        return 64'sh1_0000_0000 / d;
    endfunction

    function automatic logic signed [31:0] predict_velocity(joint_beat_t j);
        logic signed [63:0] v;
        logic signed [63:0] lim;
        int active;
        active = (model_count > 6'd32) ? 32 : int'(model_count);
        if (int'(j.idx) >= active || !j.lim || j.hi <= j.lo || model_gain == 0)
            return '0;
        // >>> on a signed value rounds toward minus infinity, as required
        v = (64'(model_gain) * (recip_of_distance(64'(j.q) - 64'(j.lo))
            - recip_of_distance(64'(j.hi) - 64'(j.q)))) >>> 16;
        lim = 64'(j.vmax);
        if (lim > 0)
        begin
            if (v > lim)
                v = lim;
            else if (v < -lim)
                v = -lim;
        end
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return $signed($urandom_range(0, 64)) - 32;
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    // mostly well-formed joints: limits ordered, position near or inside range
    function automatic joint_beat_t rand_joint();
        joint_beat_t j;
        logic signed [31:0] a;
        logic signed [31:0] b;
        j.idx = 5'($urandom);
        j.lim = ($urandom_range(0, 9) != 0);
        a = rand_q16();
        b = rand_q16();
        if ($urandom_range(0, 9) != 0 && a > b)
        begin
            j.lo = b;
            j.hi = a;
        end
        else
        begin
            j.lo = a;
            j.hi = b;
        end
        case ($urandom_range(0, 4))
            0: j.q = rand_q16();
            1: j.q = j.lo + $signed($urandom_range(0, 8)) - 2;
            2: j.q = j.hi - $signed($urandom_range(0, 8)) + 2;
            default: j.q = 32'(j.lo + ((64'(j.hi) - 64'(j.lo))
                                       * $urandom_range(0, 1000)) / 1000);
        endcase
        j.vmax = ($urandom_range(0, 2) == 0) ? rand_q16()
                                             : $signed($urandom_range(0, 32'h00FF_FFFF));
        return j;
    endfunction

    function automatic joint_beat_t make_joint(logic [4:0] idx, logic lim,
        logic signed [31:0] q, logic signed [31:0] lo, logic signed [31:0] hi,
        logic signed [31:0] vmax);
        joint_beat_t j;
        j.idx = idx; j.lim = lim; j.q = q; j.lo = lo; j.hi = hi; j.vmax = vmax;
        return j;
    endfunction

    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == jlrv_pkg::CFG_GAIN)
            model_gain = data;
        else
            model_count = data[5:0];
    endtask

    // hold until every queued joint has been driven and every result seen
    task automatic drain();
        while (pending_joints.size() != 0 || expected_velocities.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // driver: bursts of pushes separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            automatic logic taken = push && !full;
            automatic bit go;
            if (taken)
                void'(pending_joints.pop_front());
            go = 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (burst_left > 0)
            begin
                go = 1'b1;
                burst_left <= burst_left - 1;
            end
            else
            begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (!taken && push)
                go = 1'b1;  // hold an unaccepted beat
            if (go && pending_joints.size() != 0)
            begin
                push         <= 1'b1;
                joint_index  <= pending_joints[0].idx;
                limit_set    <= pending_joints[0].lim;
                position     <= pending_joints[0].q;
                lower_limit  <= pending_joints[0].lo;
                upper_limit  <= pending_joints[0].hi;
                vel_limit    <= pending_joints[0].vmax;
            end
            else
                push <= 1'b0;
            if (taken)
            begin
                // predict on the beat that the block just took
                automatic joint_beat_t j;
                automatic velocity_beat_t e;
                j = make_joint(joint_index, limit_set, position, lower_limit,
                               upper_limit, vel_limit);
                e.idx = j.idx;
                e.vel = predict_velocity(j);
                expected_velocities.push_back(e);
            end
        end
    end

    // pop pattern: periodic stall phases, switched at random between runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_phase <= 0;
            pop_mode <= 1'b0;
        end
        else
        begin
            pop_phase <= (pop_phase == 63) ? 0 : pop_phase + 1;
            if (pop_phase == 63)
                pop_mode <= ($urandom_range(0, 1) != 0);
            if (pop_mode)
                pop <= 1'b1;
            else
                pop <= (pop_phase[4:2] != 3'd5) && ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each popped beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_velocities.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected beat: joint %0d velocity %0d", joint_out, velocity);
            end
            else
            begin
                automatic velocity_beat_t e = expected_velocities.pop_front();
                if (e.idx !== joint_out || e.vel !== velocity)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected joint %0d vel %0d, got joint %0d vel %0d",
                                 e.idx, e.vel, joint_out, velocity);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase;
        mismatches = 0;
        model_gain = '0;
        model_count = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = jlrv_pkg::CFG_GAIN;
        cfg_data = '0;
        joint_index = '0;
        limit_set = 1'b0;
        position = '0;
        lower_limit = '0;
        upper_limit = '0;
        vel_limit = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers give zero, then edge cases
        pending_joints.push_back(make_joint(0, 1, 0, -32'sd65536, 32'sd65536, 0));
        drain();
        write_reg(jlrv_pkg::CFG_GAIN, 32'h0001_0000);
        write_reg(jlrv_pkg::CFG_COUNT, 6'd32);
        pending_joints.push_back(make_joint(31, 1, 0, -32'sd65536, 32'sd131072, 0));
        pending_joints.push_back(make_joint(3, 0, 0, -32'sd65536, 32'sd65536, 0));
        pending_joints.push_back(make_joint(4, 1, 0, 32'sd65536, 32'sd65536, 0));
        pending_joints.push_back(make_joint(5, 1, 0, 32'sd65536, -32'sd65536, 0));
        pending_joints.push_back(make_joint(6, 1, -32'sd65536, -32'sd65536, 32'sd65536, 0));
        pending_joints.push_back(make_joint(7, 1, 32'sd65536, -32'sd65536, 32'sd65536, 0));
        pending_joints.push_back(make_joint(8, 1, -32'sd99999, -32'sd65536, 32'sd65536, 0));
        pending_joints.push_back(make_joint(9, 1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        pending_joints.push_back(make_joint(10, 1, 32'sh8000_0000, 32'sh8000_0000,
                                            32'sh7FFF_FFFF, 32'sd100));
        pending_joints.push_back(make_joint(11, 1, 1, 0, 32'sd65536, 32'sh8000_0000));
        pending_joints.push_back(make_joint(12, 1, 32'sd65535, 0, 32'sd65536, -32'sd5));
        drain();
        write_reg(jlrv_pkg::CFG_GAIN, 32'h7FFF_FFFF);
        write_reg(jlrv_pkg::CFG_COUNT, 6'd63);
        pending_joints.push_back(make_joint(31, 1, 0, 0, 32'sd65536, 0));
        pending_joints.push_back(make_joint(1, 1, 32'sd65536, 0, 32'sd65536, 0));
        pending_joints.push_back(make_joint(2, 1, 32'sd65536, 0, 32'sd65536, 32'sd1000));
        drain();
        write_reg(jlrv_pkg::CFG_GAIN, 32'h8000_0000);
        write_reg(jlrv_pkg::CFG_COUNT, 6'd4);
        pending_joints.push_back(make_joint(0, 1, 0, 0, 32'sd65536, 0));
        pending_joints.push_back(make_joint(3, 1, 32'sd65536, 0, 32'sd65536, 0));
        pending_joints.push_back(make_joint(4, 1, 32'sd65536, 0, 32'sd65536, 0));
        drain();
        write_reg(jlrv_pkg::CFG_COUNT, 6'd0);
        pending_joints.push_back(make_joint(0, 1, 0, 0, 32'sd65536, 0));
        drain();

        // random phases over a spread of settings, extremes included
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_reg(jlrv_pkg::CFG_GAIN, 32'h0000_0001);
                1: write_reg(jlrv_pkg::CFG_GAIN, 32'h7FFF_FFFF);
                2: write_reg(jlrv_pkg::CFG_GAIN, 32'h8000_0000);
                3: write_reg(jlrv_pkg::CFG_GAIN, 32'h0000_0000);
                default: write_reg(jlrv_pkg::CFG_GAIN, $urandom_range(0, 1) ? $urandom
                                   : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            endcase
            write_reg(jlrv_pkg::CFG_COUNT, (phase == 0) ? 6'd32 : (phase == 1) ? 6'd63
                                 : $urandom_range(0, 63));
            repeat (240) pending_joints.push_back(rand_joint());
            drain();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
